// ===== rtl/core/bst_pkg.sv =====
// bst_pkg: shared types and constants of the binned score table
// used by bst_div, bst_mac and binned_score_table_bilinear_top
`timescale 1ns / 1ps

package bst_pkg;

  localparam int CELL_W    = 48;
  localparam int COORD_W   = 32;
  localparam int WGT_W     = 33;
  localparam int FRAC_W    = 32;
  localparam int DIV_NUM_W = 80;
  localparam int DIV_CNT_W = 7;
  localparam int MAC_ACC_W = 80;
  localparam int MAC_CNT_W = 6;

  localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};
  localparam logic [WGT_W-1:0]  ONE_Q32  = {1'b1, {FRAC_W{1'b0}}};

  // status codes
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NO_TOTAL = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_INTERP = 2'd0;
  localparam logic [1:0] CFG_DBINS  = 2'd1;
  localparam logic [1:0] CFG_ABINS  = 2'd2;

  typedef enum logic [2:0] {
    OP_WR_DIST  = 3'd0,
    OP_WR_ANGLE = 3'd1,
    OP_INCR     = 3'd2,
    OP_SCORE    = 3'd3,
    OP_PREFIX   = 3'd4,
    OP_PROB     = 3'd5,
    OP_ECDF     = 3'd6
  } op_t;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE,
    S_DS_RD, S_DS_CMP, S_AS_RD, S_AS_CMP,
    S_PT_SET, S_PT_RD, S_PT_USE,
    S_WD_GO, S_WD_WT, S_WA_GO, S_WA_WT,
    S_IF_SET, S_IF_RD, S_IF_CAP,
    S_BL_A, S_BL_AW, S_BL_B, S_BL_BW,
    S_PS_SET, S_PS_RD, S_PS_ORIG, S_PS_RD2, S_PS_UP, S_PS_WR,
    S_NS_SET, S_NS_RD, S_NS_ACC,
    S_NL_RD, S_NL_CAP, S_N_CHK,
    S_ND_SET, S_ND_RD, S_ND_GO, S_ND_WT,
    S_FIN
  } state_t;

  // handshake of the shared iterative units
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_req_t;

  function automatic logic [CELL_W-1:0] sat_add(input logic [CELL_W-1:0] a,
                                                input logic [CELL_W-1:0] b);
    logic [CELL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CELL_W] ? CELL_MAX : s[CELL_W-1:0];
  endfunction

endpackage

// ===== rtl/core/bst_div.sv =====
// bst_div: restoring divider, one quotient bit per cycle, 48-bit quotient with an overflow flag
// depends on bst_pkg
`timescale 1ns / 1ps

module bst_div import bst_pkg::*; #(
  parameter int DEN_W = 55
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIV_NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]      den,
  output unit_sts_t             sts,
  output logic [CELL_W-1:0]     quo,
  output logic                  ovf
);

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] n_r;
  logic [DEN_W-1:0]     den_r, rem_r;
  logic [CELL_W-1:0]    q_r;
  logic                 ovf_r;
  logic [DEN_W:0]       rs, rdiff;
  logic                 ge;

  // one restoring step
  always_comb begin
    rs    = {rem_r, n_r[DIV_NUM_W-1]};
    rdiff = rs - {1'b0, den_r};
    ge    = (rs >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      n_r   <= {n_r[DIV_NUM_W-2:0], 1'b0};
      rem_r <= ge ? rdiff[DEN_W-1:0] : rs[DEN_W-1:0];
      q_r   <= {q_r[CELL_W-2:0], ge};
      ovf_r <= ovf_r | q_r[CELL_W-1];
    end
  end

  assign sts = '{busy: busy_r, done: done_r};
  assign quo = q_r;
  assign ovf = ovf_r;

endmodule

// ===== rtl/core/bst_mac.sv =====
// bst_mac: shift-and-add multiply-accumulate, one multiplier bit per cycle
// depends on bst_pkg
`timescale 1ns / 1ps

module bst_mac import bst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mac_req_t              req,
  input  logic [CELL_W-1:0]     mcand,
  input  logic [WGT_W-1:0]      mplr,
  output unit_sts_t             sts,
  output logic [MAC_ACC_W-1:0]  acc
);

  logic                 busy_r, done_r;
  logic [MAC_CNT_W-1:0] cnt_r;
  logic [MAC_ACC_W-1:0] acc_r, md_r;
  logic [WGT_W-1:0]     mr_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MAC_CNT_W'(WGT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      md_r <= MAC_ACC_W'(mcand);
      mr_r <= mplr;
      if (req.clear) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      if (mr_r[0]) begin
        acc_r <= acc_r + md_r;
      end
      md_r <= {md_r[MAC_ACC_W-2:0], 1'b0};
      mr_r <= {1'b0, mr_r[WGT_W-1:1]};
    end
  end

  assign sts = '{busy: busy_r, done: done_r};
  assign acc = acc_r;

endmodule

// ===== rtl/core/binned_score_table_bilinear_top.sv =====
// binned_score_table_bilinear_top: 2d binned score table with bilinear lookup
// depends on bst_pkg, bst_div, bst_mac
//
// Usage:
//  - in_* channel (valid/ready) carries one operation per transaction: edge
//    write, increment, score query, prefix sum, probability or ecdf normalise.
//  - out_* channel (valid/ready) returns exactly one transaction per input:
//    the score (zero for other ops) and a status bit (1 = zero total).
//  - cfg_* is a plain write port (interpolate enable, used row/column counts);
//    the user must write it only while idle; the block does not enforce this.
//  - one sequencer drives a single-port cell memory, a shared serial divider
//    and a shared serial multiply-accumulate; in_ready is high only while the
//    sequencer is idle.
//  - an interpolated score adds two divisions, three cell reads and six products
//    to a plain score; probability and ecdf divide each used cell by the total.
//  - after reset the cell memory is cleared one entry a cycle,
//    all DIST_BINS*ANGLE_BINS entries, with in_ready low.
//  - a finished result waits in the output register; the next transaction may
//    be accepted meanwhile, and the sequencer holds at its end until the
//    output register is free.
`timescale 1ns / 1ps

module binned_score_table_bilinear_top import bst_pkg::*; #(
  parameter int DIST_BINS  = 16,
  parameter int ANGLE_BINS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [4:0]                cfg_wdata,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_op,
  input  logic [3:0]                in_edge_index,
  input  logic signed [COORD_W-1:0] in_distance_coord,
  input  logic signed [COORD_W-1:0] in_angle_coord,
  input  logic [CELL_W-1:0]         in_add_value,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CELL_W-1:0]         out_result_value,
  output logic                      out_status
);

  localparam int NCELL  = DIST_BINS * ANGLE_BINS;
  localparam int DI_W   = (DIST_BINS > 1) ? $clog2(DIST_BINS) : 1;
  localparam int AI_W   = (ANGLE_BINS > 1) ? $clog2(ANGLE_BINS) : 1;
  localparam int CA_W   = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int DCNT_W = $clog2(DIST_BINS + 1);
  localparam int ACNT_W = $clog2(ANGLE_BINS + 1);
  localparam int TOT_W  = CELL_W + CA_W;

  function automatic logic [CA_W-1:0] caddr_of(input logic [DI_W-1:0] r,
                                               input logic [AI_W-1:0] c);
    caddr_of = CA_W'(int'(r) * ANGLE_BINS + int'(c));
  endfunction

  // configuration registers
  logic       ie_r;
  logic [4:0] dbu_r;
  logic [3:0] abu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ie_r  <= 1'b1;
      dbu_r <= 5'd16;
      abu_r <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERP: ie_r  <= cfg_wdata[0];
        CFG_DBINS:  dbu_r <= cfg_wdata;
        CFG_ABINS:  abu_r <= cfg_wdata[3:0];
        default:    ;
      endcase
    end
  end

  // used counts, clamped to [1, bins]
  logic [DCNT_W-1:0] nd;
  logic [ACNT_W-1:0] na;

  always_comb begin
    if (dbu_r == '0) begin
      nd = DCNT_W'(1);
    end else if ({3'b0, dbu_r} > 8'(DIST_BINS)) begin
      nd = DCNT_W'(DIST_BINS);
    end else begin
      nd = DCNT_W'(dbu_r);
    end
    if (abu_r == '0) begin
      na = ACNT_W'(1);
    end else if ({4'b0, abu_r} > 8'(ANGLE_BINS)) begin
      na = ACNT_W'(ANGLE_BINS);
    end else begin
      na = ACNT_W'(abu_r);
    end
  end

  // sequencer registers
  state_t                    state_r, state_nxt;
  logic [DI_W-1:0]           i_r, i_nxt;
  logic [AI_W-1:0]           j_r, j_nxt;
  logic [CA_W-1:0]           caddr_r, caddr_nxt;
  op_t                       op_r, op_nxt;
  logic signed [COORD_W-1:0] d_r, d_nxt, a_r, a_nxt;
  logic [CELL_W-1:0]         add_r, add_nxt;
  logic                      pd_r, pd_nxt, pa_r, pa_nxt;
  logic signed [COORD_W-1:0] x0_r, x0_nxt, x1_r, x1_nxt;
  logic signed [COORD_W-1:0] y0_r, y0_nxt, y1_r, y1_nxt;
  logic [WGT_W-1:0]          dx_r, dx_nxt, dy_r, dy_nxt;
  logic [CELL_W-1:0]         f00_r, f00_nxt, f01_r, f01_nxt;
  logic [CELL_W-1:0]         f10_r, f10_nxt, f11_r, f11_nxt;
  logic [CELL_W-1:0]         fx0_r, fx0_nxt, fx1_r, fx1_nxt;
  logic [CELL_W-1:0]         run_r, run_nxt, v_r, v_nxt;
  logic [TOT_W-1:0]          tot_r, tot_nxt;
  logic [1:0]                fr_r, fr_nxt, bl_r, bl_nxt;
  logic [CELL_W-1:0]         res_r, res_nxt;
  logic                      st_r, st_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]         out_res_r, out_res_nxt;
  logic                      out_st_r, out_st_nxt;

  // memories
  logic [COORD_W-1:0] dmem [DIST_BINS];
  logic [COORD_W-1:0] amem [ANGLE_BINS];
  logic [CELL_W-1:0]  cmem [NCELL];
  logic [COORD_W-1:0] drd_r, ard_r;
  logic [CELL_W-1:0]  cq_r;
  logic               cwe;
  logic [CELL_W-1:0]  cwd;
  logic               in_fire;

  assign in_fire = in_valid && in_ready;

  // edge memories, written on accept
  always_ff @(posedge clk) begin
    if (in_fire && (op_t'(in_op) == OP_WR_DIST) &&
        ({4'b0, in_edge_index} < 8'(DIST_BINS))) begin
      dmem[DI_W'(in_edge_index)] <= in_distance_coord;
    end
    if (in_fire && (op_t'(in_op) == OP_WR_ANGLE) &&
        ({4'b0, in_edge_index} < 8'(ANGLE_BINS))) begin
      amem[AI_W'(in_edge_index)] <= in_distance_coord;
    end
    drd_r <= dmem[i_r];
    ard_r <= amem[j_r];
  end

  // cell memory, single address
  always_ff @(posedge clk) begin
    if (cwe) begin
      cmem[caddr_r] <= cwd;
    end
    cq_r <= cmem[caddr_r];
  end

  // shared units
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [TOT_W-1:0]     div_den;
  unit_sts_t            div_sts;
  logic [CELL_W-1:0]    div_quo;
  logic                 div_ovf;
  mac_req_t             mac_req;
  logic [CELL_W-1:0]    mac_a;
  logic [WGT_W-1:0]     mac_w;
  unit_sts_t            mac_sts;
  logic [MAC_ACC_W-1:0] mac_acc;

  bst_div #(.DEN_W(TOT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .sts   (div_sts),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  bst_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .mcand (mac_a),
    .mplr  (mac_w),
    .sts   (mac_sts),
    .acc   (mac_acc)
  );

  // walk over used cells, row by row
  logic            last_i, last_j, walk_last;
  logic [DI_W-1:0] wi_nxt;
  logic [AI_W-1:0] wj_nxt;

  always_comb begin
    last_i    = (DCNT_W'(i_r) == nd - DCNT_W'(1));
    last_j    = (ACNT_W'(j_r) == na - ACNT_W'(1));
    walk_last = last_i && last_j;
    wi_nxt    = last_j ? i_r + 1'b1 : i_r;
    wj_nxt    = last_j ? '0 : j_r + 1'b1;
  end

  // blend operands and weight differences
  logic [CELL_W-1:0]  bl_a, bl_b;
  logic [WGT_W-1:0]   bl_w;
  logic [COORD_W:0]   wnum, wden;
  logic [DI_W-1:0]    fr_row;
  logic [AI_W-1:0]    fr_col;

  always_comb begin
    case (bl_r)
      2'd0:    begin bl_a = f00_r; bl_b = f10_r; bl_w = dx_r; end
      2'd1:    begin bl_a = f01_r; bl_b = f11_r; bl_w = dx_r; end
      default: begin bl_a = fx0_r; bl_b = fx1_r; bl_w = dy_r; end
    endcase
    if (state_r == S_WA_GO) begin
      wnum = {a_r[COORD_W-1], a_r} - {y0_r[COORD_W-1], y0_r};
      wden = {y1_r[COORD_W-1], y1_r} - {y0_r[COORD_W-1], y0_r};
    end else begin
      wnum = {d_r[COORD_W-1], d_r} - {x0_r[COORD_W-1], x0_r};
      wden = {x1_r[COORD_W-1], x1_r} - {x0_r[COORD_W-1], x0_r};
    end
    fr_row = (fr_r == 2'd1) ? i_r : i_r - 1'b1;
    fr_col = (fr_r == 2'd2) ? j_r : j_r - 1'b1;
  end

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      caddr_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      caddr_r     <= caddr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;     j_r <= j_nxt;     op_r <= op_nxt;
    d_r <= d_nxt;     a_r <= a_nxt;     add_r <= add_nxt;
    pd_r <= pd_nxt;   pa_r <= pa_nxt;
    x0_r <= x0_nxt;   x1_r <= x1_nxt;   y0_r <= y0_nxt;   y1_r <= y1_nxt;
    dx_r <= dx_nxt;   dy_r <= dy_nxt;
    f00_r <= f00_nxt; f01_r <= f01_nxt; f10_r <= f10_nxt; f11_r <= f11_nxt;
    fx0_r <= fx0_nxt; fx1_r <= fx1_nxt;
    run_r <= run_nxt; v_r <= v_nxt;     tot_r <= tot_nxt;
    fr_r <= fr_nxt;   bl_r <= bl_nxt;
    res_r <= res_nxt; st_r <= st_nxt;
    out_res_r <= out_res_nxt;
    out_st_r  <= out_st_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;       j_nxt = j_r;       caddr_nxt = caddr_r;
    op_nxt = op_r;     d_nxt = d_r;       a_nxt = a_r;     add_nxt = add_r;
    pd_nxt = pd_r;     pa_nxt = pa_r;
    x0_nxt = x0_r;     x1_nxt = x1_r;     y0_nxt = y0_r;   y1_nxt = y1_r;
    dx_nxt = dx_r;     dy_nxt = dy_r;
    f00_nxt = f00_r;   f01_nxt = f01_r;   f10_nxt = f10_r; f11_nxt = f11_r;
    fx0_nxt = fx0_r;   fx1_nxt = fx1_r;
    run_nxt = run_r;   v_nxt = v_r;       tot_nxt = tot_r;
    fr_nxt = fr_r;     bl_nxt = bl_r;
    res_nxt = res_r;   st_nxt = st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt = out_res_r;
    out_st_nxt  = out_st_r;
    in_ready  = 1'b0;
    cwe       = 1'b0;
    cwd       = '0;
    div_start = 1'b0;
    div_num   = {16'b0, wnum[COORD_W-1:0], {FRAC_W{1'b0}}};
    div_den   = TOT_W'(wden[COORD_W-1:0]);
    mac_req   = '{start: 1'b0, clear: 1'b0};
    mac_a     = bl_a;
    mac_w     = ONE_Q32 - bl_w;

    unique case (state_r)
      // zero the cell memory after reset
      S_CLEAR: begin
        cwe = 1'b1;
        caddr_nxt = caddr_r + 1'b1;
        if (caddr_r == CA_W'(NCELL - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt  = op_t'(in_op);
          d_nxt   = in_distance_coord;
          a_nxt   = in_angle_coord;
          add_nxt = in_add_value;
          res_nxt = '0;
          st_nxt  = ST_OK;
          i_nxt   = '0;
          j_nxt   = '0;
          tot_nxt = '0;
          run_nxt = '0;
          case (in_op) inside
            OP_INCR, OP_SCORE: state_nxt = S_DS_RD;
            OP_PREFIX:         state_nxt = S_PS_SET;
            OP_PROB:           state_nxt = S_NS_SET;
            OP_ECDF: begin
              caddr_nxt = caddr_of(DI_W'(nd - DCNT_W'(1)), AI_W'(na - ACNT_W'(1)));
              state_nxt = S_NL_RD;
            end
            default:           state_nxt = S_FIN;
          endcase
        end
      end

      // lower-bound search over distance edges
      S_DS_RD: state_nxt = S_DS_CMP;
      S_DS_CMP: begin
        if ($signed(drd_r) >= d_r) begin
          pd_nxt = 1'b0;
          x1_nxt = drd_r;
          state_nxt = S_AS_RD;
        end else begin
          x0_nxt = drd_r;
          if (last_i) begin
            pd_nxt = 1'b1;
            state_nxt = S_AS_RD;
          end else begin
            i_nxt = i_r + 1'b1;
            state_nxt = S_DS_RD;
          end
        end
      end

      // lower-bound search over angle edges
      S_AS_RD: state_nxt = S_AS_CMP;
      S_AS_CMP: begin
        if ($signed(ard_r) >= a_r) begin
          pa_nxt = 1'b0;
          y1_nxt = ard_r;
          state_nxt = S_PT_SET;
        end else begin
          y0_nxt = ard_r;
          if (last_j) begin
            pa_nxt = 1'b1;
            state_nxt = S_PT_SET;
          end else begin
            j_nxt = j_r + 1'b1;
            state_nxt = S_AS_RD;
          end
        end
      end

      // fetch the selected cell
      S_PT_SET: begin
        caddr_nxt = caddr_of(i_r, j_r);
        state_nxt = S_PT_RD;
      end
      S_PT_RD: state_nxt = S_PT_USE;
      S_PT_USE: begin
        if (op_r == OP_INCR) begin
          cwe = 1'b1;
          cwd = sat_add(cq_r, add_r);
          state_nxt = S_FIN;
        end else if (i_r == '0 || j_r == '0 || pd_r || pa_r || !ie_r) begin
          res_nxt = cq_r;
          state_nxt = S_FIN;
        end else begin
          f11_nxt = cq_r;
          state_nxt = S_WD_GO;
        end
      end

      // interpolation weights
      S_WD_GO: begin
        div_start = 1'b1;
        state_nxt = S_WD_WT;
      end
      S_WD_WT: begin
        if (div_sts.done) begin
          dx_nxt = div_quo[WGT_W-1:0];
          state_nxt = S_WA_GO;
        end
      end
      S_WA_GO: begin
        div_start = 1'b1;
        state_nxt = S_WA_WT;
      end
      S_WA_WT: begin
        if (div_sts.done) begin
          dy_nxt = div_quo[WGT_W-1:0];
          fr_nxt = 2'd0;
          state_nxt = S_IF_SET;
        end
      end

      // fetch the three lower neighbours
      S_IF_SET: begin
        caddr_nxt = caddr_of(fr_row, fr_col);
        state_nxt = S_IF_RD;
      end
      S_IF_RD: state_nxt = S_IF_CAP;
      S_IF_CAP: begin
        case (fr_r)
          2'd0:    f00_nxt = cq_r;
          2'd1:    f10_nxt = cq_r;
          default: f01_nxt = cq_r;
        endcase
        if (fr_r == 2'd2) begin
          bl_nxt = 2'd0;
          state_nxt = S_BL_A;
        end else begin
          fr_nxt = fr_r + 1'b1;
          state_nxt = S_IF_SET;
        end
      end

      // blend: a*(1-w) + b*w, then drop the fraction
      S_BL_A: begin
        mac_req = '{start: 1'b1, clear: 1'b1};
        state_nxt = S_BL_AW;
      end
      S_BL_AW: if (mac_sts.done) state_nxt = S_BL_B;
      S_BL_B: begin
        mac_req = '{start: 1'b1, clear: 1'b0};
        mac_a = bl_b;
        mac_w = bl_w;
        state_nxt = S_BL_BW;
      end
      S_BL_BW: begin
        if (mac_sts.done) begin
          case (bl_r)
            2'd0:    fx0_nxt = mac_acc[MAC_ACC_W-1:FRAC_W];
            2'd1:    fx1_nxt = mac_acc[MAC_ACC_W-1:FRAC_W];
            default: res_nxt = mac_acc[MAC_ACC_W-1:FRAC_W];
          endcase
          if (bl_r == 2'd2) begin
            state_nxt = S_FIN;
          end else begin
            bl_nxt = bl_r + 1'b1;
            state_nxt = S_BL_A;
          end
        end
      end

      // in-place 2d prefix sum
      S_PS_SET: begin
        caddr_nxt = caddr_of(i_r, j_r);
        state_nxt = S_PS_RD;
      end
      S_PS_RD: state_nxt = S_PS_ORIG;
      S_PS_ORIG: begin
        v_nxt   = sat_add(cq_r, run_r);
        run_nxt = sat_add(cq_r, run_r);
        if (i_r != '0) begin
          caddr_nxt = caddr_of(i_r - 1'b1, j_r);
          state_nxt = S_PS_RD2;
        end else begin
          state_nxt = S_PS_WR;
        end
      end
      S_PS_RD2: state_nxt = S_PS_UP;
      S_PS_UP: begin
        v_nxt = sat_add(v_r, cq_r);
        caddr_nxt = caddr_of(i_r, j_r);
        state_nxt = S_PS_WR;
      end
      S_PS_WR: begin
        cwe = 1'b1;
        cwd = v_r;
        if (last_j) begin
          run_nxt = '0;
        end
        if (walk_last) begin
          state_nxt = S_FIN;
        end else begin
          i_nxt = wi_nxt;
          j_nxt = wj_nxt;
          state_nxt = S_PS_SET;
        end
      end

      // grand total
      S_NS_SET: begin
        caddr_nxt = caddr_of(i_r, j_r);
        state_nxt = S_NS_RD;
      end
      S_NS_RD: state_nxt = S_NS_ACC;
      S_NS_ACC: begin
        tot_nxt = tot_r + TOT_W'(cq_r);
        if (walk_last) begin
          state_nxt = S_N_CHK;
        end else begin
          i_nxt = wi_nxt;
          j_nxt = wj_nxt;
          state_nxt = S_NS_SET;
        end
      end

      // last cell as total
      S_NL_RD: state_nxt = S_NL_CAP;
      S_NL_CAP: begin
        tot_nxt = TOT_W'(cq_r);
        state_nxt = S_N_CHK;
      end

      S_N_CHK: begin
        i_nxt = '0;
        j_nxt = '0;
        if (tot_r == '0) begin
          st_nxt = ST_NO_TOTAL;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_ND_SET;
        end
      end

      // divide each used cell by the total
      S_ND_SET: begin
        caddr_nxt = caddr_of(i_r, j_r);
        state_nxt = S_ND_RD;
      end
      S_ND_RD: state_nxt = S_ND_GO;
      S_ND_GO: begin
        div_start = 1'b1;
        div_num   = {cq_r, {FRAC_W{1'b0}}};
        div_den   = tot_r;
        state_nxt = S_ND_WT;
      end
      S_ND_WT: begin
        div_den = tot_r;
        if (div_sts.done) begin
          cwe = 1'b1;
          cwd = div_ovf ? CELL_MAX : div_quo;
          if (walk_last) begin
            state_nxt = S_FIN;
          end else begin
            i_nxt = wi_nxt;
            j_nxt = wj_nxt;
            state_nxt = S_ND_SET;
          end
        end
      end

      // hand the result to the output register
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_status       = out_st_r;

`ifndef SYNTHESIS
  // a unit is never restarted while it is still iterating
  assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_sts.busy)
    else $error("divider started while busy");
  assert property (@(posedge clk) disable iff (!rst_n) mac_req.start |-> !mac_sts.busy)
    else $error("mac started while busy");
  // zero-total status only comes from a normalisation
  assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_FIN && st_r) |-> (op_r == OP_PROB || op_r == OP_ECDF))
    else $error("status set by a non-normalising op");
  // cells are written only by clearing, increment, prefix sum or division
  assert property (@(posedge clk) disable iff (!rst_n)
      cwe |-> (state_r == S_CLEAR || state_r == S_PT_USE ||
               state_r == S_PS_WR || state_r == S_ND_WT))
    else $error("unexpected cell write");
`endif

endmodule

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench of binned_score_table_bilinear_top
// depends on bst_pkg and the rtl of the block; holds its own table predictor
`timescale 1ns / 1ps

module tb_top;
  import bst_pkg::*;

  localparam int NDIST  = 16;
  localparam int NANGLE = 8;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic [3:0]         eidx;
    logic signed [31:0] dcoord;
    logic signed [31:0] ang;
    logic [CELL_W-1:0]  addv;
  } table_op_t;

  typedef struct {
    logic [CELL_W-1:0] score;
    logic              status;
  } score_rsp_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_wdata;
  logic in_valid, in_ready;
  logic [2:0] in_op;
  logic [3:0] in_edge_index;
  logic signed [31:0] in_distance_coord, in_angle_coord;
  logic [CELL_W-1:0] in_add_value;
  logic out_valid, out_ready;
  logic [CELL_W-1:0] out_result_value;
  logic out_status;

  binned_score_table_bilinear_top dut (.*);

  // predicted block state
  logic              p_interp;
  logic [4:0]        p_dbins;
  logic [3:0]        p_abins;
  logic signed [31:0] p_dedge [NDIST];
  logic signed [31:0] p_aedge [NANGLE];
  logic [CELL_W-1:0] p_cell [NDIST*NANGLE];

  // edges as planned by stimulus, used to aim samples
  logic signed [31:0] plan_dedge [NDIST];
  logic signed [31:0] plan_aedge [NANGLE];

  table_op_t  pending_ops[$];
  score_rsp_t expected_rsps[$];
  int errors = 0;
  int hold_reqs = 0;

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int used_rows(logic [4:0] r);
    if (r < 1) return 1;
    if (r > NDIST) return NDIST;
    return int'(r);
  endfunction

  function automatic int used_cols(logic [3:0] r);
    if (r < 1) return 1;
    if (r > NANGLE) return NANGLE;
    return int'(r);
  endfunction

  function automatic logic [CELL_W-1:0] sadd(logic [CELL_W-1:0] a, logic [CELL_W-1:0] b);
    logic [CELL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CELL_W] ? CELL_MAX : s[CELL_W-1:0];
  endfunction

  // lower-bound search over the used edges
  function automatic int search_dist(int n, logic signed [31:0] x, output bit past);
    for (int k = 0; k < n; k++)
      if (p_dedge[k] >= x) begin
        past = 0;
        return k;
      end
    past = 1;
    return n - 1;
  endfunction

  function automatic int search_angle(int n, logic signed [31:0] x, output bit past);
    for (int k = 0; k < n; k++)
      if (p_aedge[k] >= x) begin
        past = 0;
        return k;
      end
    past = 1;
    return n - 1;
  endfunction

  // floor(cell * 2^32 / total), saturated
  function automatic logic [CELL_W-1:0] normalize(logic [CELL_W-1:0] c, logic [63:0] total);
    logic [127:0] q;
    q = ({80'd0, c} << 32) / {64'd0, total};
    return (q > CELL_MAX) ? CELL_MAX : q[CELL_W-1:0];
  endfunction

  // weight of x between lo and hi in Q1.32, both differences positive
  function automatic logic [63:0] interp_weight(logic signed [31:0] x, logic signed [31:0] lo,
                                                logic signed [31:0] hi);
    logic [63:0] num, den;
    num = 64'(x) - 64'(lo);
    den = 64'(hi) - 64'(lo);
    return (num << 32) / den;
  endfunction

  function automatic logic [CELL_W-1:0] lerp(logic [CELL_W-1:0] a, logic [CELL_W-1:0] b,
                                             logic [63:0] w);
    logic [127:0] t;
    t = 128'(a) * 128'(64'h1_0000_0000 - w) + 128'(b) * 128'(w);
    return t[32 +: CELL_W];
  endfunction

  // apply one operation to the predicted table and return its response
  function automatic score_rsp_t predict_table(table_op_t t);
    score_rsp_t r;
    int nd, na, i1, j1, i0, j0;
    bit pd, pa;
    logic [CELL_W-1:0] run, orig, v, fx0, fx1;
    logic [63:0] total, dx, dy;
    r.score = '0;
    r.status = ST_OK;
    nd = used_rows(p_dbins);
    na = used_cols(p_abins);
    case (t.op)
      OP_WR_DIST: begin
        if (t.eidx < NDIST) p_dedge[t.eidx] = t.dcoord;
      end
      OP_WR_ANGLE: begin
        if (t.eidx < NANGLE) p_aedge[t.eidx] = t.dcoord;
      end
      OP_INCR, OP_SCORE: begin
        i1 = search_dist(nd, t.dcoord, pd);
        j1 = search_angle(na, t.ang, pa);
        if (t.op == OP_INCR) begin
          p_cell[i1*NANGLE+j1] = sadd(p_cell[i1*NANGLE+j1], t.addv);
        end else if (i1 == 0 || j1 == 0 || pd || pa || !p_interp) begin
          r.score = p_cell[i1*NANGLE+j1];
        end else begin
          i0 = i1 - 1;
          j0 = j1 - 1;
          dx = interp_weight(t.dcoord, p_dedge[i0], p_dedge[i1]);
          dy = interp_weight(t.ang, p_aedge[j0], p_aedge[j1]);
          fx0 = lerp(p_cell[i0*NANGLE+j0], p_cell[i1*NANGLE+j0], dx);
          fx1 = lerp(p_cell[i0*NANGLE+j1], p_cell[i1*NANGLE+j1], dx);
          r.score = lerp(fx0, fx1, dy);
        end
      end
      OP_PREFIX: begin
        for (int i = 0; i < nd; i++) begin
          run = '0;
          for (int j = 0; j < na; j++) begin
            orig = p_cell[i*NANGLE+j];
            v = sadd(orig, run);
            run = sadd(run, orig);
            if (i > 0) v = sadd(v, p_cell[(i-1)*NANGLE+j]);
            p_cell[i*NANGLE+j] = v;
          end
        end
      end
      OP_PROB, OP_ECDF: begin
        total = '0;
        if (t.op == OP_PROB) begin
          for (int i = 0; i < nd; i++)
            for (int j = 0; j < na; j++) total += 64'(p_cell[i*NANGLE+j]);
        end else begin
          total = 64'(p_cell[(nd-1)*NANGLE+(na-1)]);
        end
        if (total == 0) begin
          r.status = ST_NO_TOTAL;
        end else begin
          for (int i = 0; i < nd; i++)
            for (int j = 0; j < na; j++)
              p_cell[i*NANGLE+j] = normalize(p_cell[i*NANGLE+j], total);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // in_ready seen at the last rising edge
  logic in_ready_seen;

  // driver: bursts of transactions with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_op <= OP_UNUSED;
      in_edge_index <= '0;
      in_distance_coord <= '0;
      in_angle_coord <= '0;
      in_add_value <= '0;
    end else if (!in_valid || (in_valid && in_ready_seen)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        table_op_t t;
        t = pending_ops.pop_front();
        in_op <= t.op;
        in_edge_index <= t.eidx;
        in_distance_coord <= t.dcoord;
        in_angle_coord <= t.ang;
        in_add_value <= t.addv;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern with mode changes, plus requested long holds
  int ready_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int hold_seen = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 600;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk) begin
    in_ready_seen <= in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("result transaction with no expectation waiting");
          errors++;
        end else begin
          score_rsp_t e;
          e = expected_rsps.pop_front();
          if (out_result_value !== e.score) begin
            $error("result_value expected %h actual %h", e.score, out_result_value);
            errors++;
          end
          if (out_status !== e.status) begin
            $error("status expected %b actual %b", e.status, out_status);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        table_op_t t;
        t.op = in_op;
        t.eidx = in_edge_index;
        t.dcoord = in_distance_coord;
        t.ang = in_angle_coord;
        t.addv = in_add_value;
        expected_rsps.push_back(predict_table(t));
      end
    end
  end

  function automatic table_op_t mk(logic [2:0] op, logic [3:0] idx, logic signed [31:0] d,
                                   logic signed [31:0] a, logic [CELL_W-1:0] v);
    table_op_t t;
    t.op = op;
    t.eidx = idx;
    t.dcoord = d;
    t.ang = a;
    t.addv = v;
    return t;
  endfunction

  task automatic push_op(logic [2:0] op, logic [3:0] idx, logic signed [31:0] d,
                         logic signed [31:0] a, logic [CELL_W-1:0] v);
    pending_ops.push_back(mk(op, idx, d, a, v));
    if (op == OP_WR_DIST && idx < NDIST) plan_dedge[idx] = d;
    if (op == OP_WR_ANGLE && idx < NANGLE) plan_aedge[idx] = d;
  endtask

  // ascending edges, equal neighbors now and then
  task automatic write_edges();
    logic signed [31:0] e;
    e = -$signed(32'($urandom_range(0, 32'h4000_0000)));
    for (int k = 0; k < NDIST; k++) begin
      push_op(OP_WR_DIST, 4'(k), e, $urandom, CELL_W'({$urandom, $urandom}));
      e += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32'h0100_0000);
    end
    e = -$signed(32'($urandom_range(0, 32'h0002_0000)));
    for (int k = 0; k < NANGLE; k++) begin
      push_op(OP_WR_ANGLE, 4'(k), e, $urandom, CELL_W'({$urandom, $urandom}));
      e += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32'h0000_8000);
    end
  endtask

  function automatic logic signed [31:0] aim_dist();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return plan_dedge[$urandom_range(0, NDIST-1)];
      default: return plan_dedge[$urandom_range(0, NDIST-1)] - $urandom_range(0, 32'h0100_0000);
    endcase
  endfunction

  function automatic logic signed [31:0] aim_angle();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return plan_aedge[$urandom_range(0, NANGLE-1)];
      default: return plan_aedge[$urandom_range(0, NANGLE-1)] - $urandom_range(0, 32'h8000);
    endcase
  endfunction

  function automatic logic [CELL_W-1:0] rand_add();
    case ($urandom_range(0, 5))
      0: return CELL_MAX;
      1: return CELL_W'({$urandom, $urandom});
      2: return CELL_W'($urandom_range(0, 15));
      default: return {16'd0, $urandom};
    endcase
  endfunction

  task automatic push_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      push_op(OP_INCR, 4'($urandom), aim_dist(), aim_angle(), rand_add());
    else if (pick < 80)
      push_op(OP_SCORE, 4'($urandom), aim_dist(), aim_angle(),
              CELL_W'({$urandom, $urandom}));
    else if (pick < 86)
      push_op($urandom_range(0, 1) ? OP_WR_DIST : OP_WR_ANGLE, 4'($urandom), aim_dist(),
              $urandom, CELL_W'({$urandom, $urandom}));
    else if (pick < 90)
      push_op(OP_PREFIX, 4'($urandom), $urandom, $urandom, CELL_W'({$urandom, $urandom}));
    else if (pick < 93)
      push_op(OP_PROB, 4'($urandom), $urandom, $urandom, CELL_W'({$urandom, $urandom}));
    else if (pick < 97)
      push_op(OP_ECDF, 4'($urandom), $urandom, $urandom, CELL_W'({$urandom, $urandom}));
    else
      push_op(OP_UNUSED, 4'($urandom), $urandom, $urandom, CELL_W'({$urandom, $urandom}));
  endtask

  task automatic wait_idle();
    while (pending_ops.size() > 0 || expected_rsps.size() > 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [4:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_INTERP) p_interp = val[0];
    else if (idx == CFG_DBINS) p_dbins = val;
    else if (idx == CFG_ABINS) p_abins = val[3:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stimulus
  initial begin
    static logic [4:0] dset [8] = '{16, 4, 1, 0, 31, 5, 16, 3};
    static logic [4:0] aset [8] = '{8, 3, 1, 0, 15, 2, 8, 8};
    static logic       iset [8] = '{1, 0, 1, 1, 1, 1, 0, 1};
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_INTERP;
    cfg_wdata = '0;
    p_interp = 1;
    p_dbins = 16;
    p_abins = 8;
    foreach (p_cell[k]) p_cell[k] = '0;
    foreach (p_dedge[k]) p_dedge[k] = '0;
    foreach (p_aedge[k]) p_aedge[k] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: edges at the coordinate extremes, empty normalise, saturation
    for (int k = 0; k < NDIST; k++)
      push_op(OP_WR_DIST, 4'(k), (k == 0) ? 32'sh8000_0000 :
              (k == NDIST-1) ? 32'sh7fff_ffff : (k - 8) <<< 16, 0, 0);
    for (int k = 0; k < NANGLE; k++)
      push_op(OP_WR_ANGLE, 4'(k), (k == NANGLE-1) ? 32'sh7fff_ffff : (k - 4) <<< 14, 0, 0);
    push_op(OP_WR_ANGLE, 4'hf, 32'sh1234_5678, 0, 0);
    push_op(OP_PROB, 0, 0, 0, 0);
    push_op(OP_ECDF, 0, 0, 0, 0);
    push_op(OP_INCR, 0, 32'sh8000_0000, 32'sh8000_0000, CELL_MAX);
    push_op(OP_INCR, 0, 32'sh8000_0000, 32'sh8000_0000, CELL_MAX);
    push_op(OP_INCR, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 48'h1_0000_0000);
    push_op(OP_INCR, 0, 32'sh0000_8000, 32'sh0000_2000, 48'h3_0000_0000);
    push_op(OP_SCORE, 0, 32'sh0000_8000, 32'sh0000_2000, 0);
    push_op(OP_SCORE, 0, 32'sh8000_0000, 32'sh8000_0000, 0);
    push_op(OP_PREFIX, 0, 0, 0, 0);
    push_op(OP_SCORE, 0, 32'sh0001_0000, 32'sh0000_0000, 0);
    push_op(OP_ECDF, 0, 0, 0, 0);
    push_op(OP_PROB, 0, 0, 0, 0);
    push_op(OP_UNUSED, 4'hf, 32'shffff_ffff, 32'shffff_ffff, CELL_MAX);
    wait_idle();

    // random phases over several configurations
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(CFG_INTERP, 5'(iset[ph]));
      write_cfg(CFG_DBINS, dset[ph]);
      write_cfg(CFG_ABINS, aset[ph]);
      write_edges();
      if (ph == 1) hold_reqs++;
      for (int n = 0; n < 165; n++) push_random();
      wait_idle();
    end

    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
